>>> hw/rtl/dmnt_pkg.sv
// ---------------------------------------------------------------------------
// Name table package
// Shared widths, defaults, operation codes and control structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dmnt_pkg;

   localparam int FUNC_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int VALUE_W    = 16;
   localparam int SLOT_OUT_W = 4;

   localparam int SLOTS_DEF      = 16;
   localparam int NAME_MAX_DEF   = 256;
   localparam int VALUE_BITS_DEF = 16;

   // (h + c) * c stays below 2^17 for any slot count up to 256.
   localparam int PROD_W = 17;
   localparam int MUL_W  = 2 * PROD_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_LOOKUP = 2'd1,
      FUNC_DELETE = 2'd2
   } func_type;

   typedef struct packed {
      logic     start;
      func_type func;
   } store_cmd_type;

   typedef struct packed {
      logic done;
      logic ok;
   } store_stat_type;

endpackage

`default_nettype wire

>>> hw/rtl/dmnt_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one name byte and its operation per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dmnt_req_if import dmnt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [CHAR_W-1:0]   name_char;
   logic                last;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, func, name_char, last, value, input ready);
   modport sink   (input valid, func, name_char, last, value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dmnt_rsp_if.sv
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the outcome of one table operation per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dmnt_rsp_if import dmnt_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  ok;
   logic [SLOT_OUT_W-1:0] slot;
   logic [VALUE_W-1:0]    found_value;

   modport source (output valid, ok, slot, found_value, input ready);
   modport sink   (input valid, ok, slot, found_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dmnt_hash.sv
// ---------------------------------------------------------------------------
// Slot hash unit
// Computes ((acc + c) * c) mod SLOTS with one shared multiplier, used for the
// product, the reciprocal quotient estimate and the back-multiplication.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmnt_hash import dmnt_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [$clog2(SLOTS)-1:0]   acc_in,
   input  logic [CHAR_W-1:0]          char_in,
   output logic                       done,
   output logic [$clog2(SLOTS)-1:0]   result
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int REM_W  = SLOT_W + 1;
   localparam int RECIP  = (1 << PROD_W) / SLOTS;

   typedef enum logic [2:0] {
      H_IDLE,
      H_PROD,
      H_QUOT,
      H_BACK,
      H_FIX
   } hash_state_type;

   hash_state_type     state_ff, state_in;
   logic [PROD_W-1:0]  a_ff, a_in;
   logic [PROD_W-1:0]  b_ff, b_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [SLOT_W-1:0]  result_ff, result_in;
   logic               done_ff, done_in;
   logic [MUL_W-1:0]   mul;

   assign mul = MUL_W'(a_ff) * MUL_W'(b_ff);

   always_comb begin
      state_in  = state_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      result_in = result_ff;
      done_in   = 1'b0;
      case (state_ff)
         H_IDLE: begin
            if (start) begin
               a_in     = PROD_W'(acc_in) + PROD_W'(char_in);
               b_in     = PROD_W'(char_in);
               state_in = H_PROD;
            end
         end
         H_PROD: begin
            prod_in  = mul[PROD_W-1:0];
            a_in     = mul[PROD_W-1:0];
            b_in     = PROD_W'(RECIP);
            state_in = H_QUOT;
         end
         H_QUOT: begin
            // The estimate is the true quotient or one below it.
            a_in     = mul[MUL_W-1:PROD_W];
            b_in     = PROD_W'(SLOTS);
            state_in = H_BACK;
         end
         H_BACK: begin
            rem_in   = REM_W'(prod_ff - mul[PROD_W-1:0]);
            state_in = H_FIX;
         end
         H_FIX: begin
            if (rem_ff >= REM_W'(SLOTS)) begin
               result_in = SLOT_W'(rem_ff - REM_W'(SLOTS));
            end else begin
               result_in = SLOT_W'(rem_ff);
            end
            done_in  = 1'b1;
            state_in = H_IDLE;
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      a_ff      <= a_in;
      b_ff      <= b_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

>>> hw/rtl/dmnt_store.sv
// ---------------------------------------------------------------------------
// Name table store
// Holds the key buffer and the slot memories, and walks a name one byte per
// cycle to copy it in on insert or to compare it on lookup and delete.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dmnt_store import dmnt_pkg::*; #(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int NAME_MAX   = NAME_MAX_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            key_wr_en,
   input  logic [$clog2(NAME_MAX)-1:0]     key_wr_addr,
   input  logic [CHAR_W-1:0]               key_wr_data,
   input  store_cmd_type                   cmd,
   input  logic [$clog2(SLOTS)-1:0]        cmd_slot,
   input  logic [$clog2(NAME_MAX+1)-1:0]   cmd_len,
   input  logic [VALUE_BITS-1:0]           cmd_value,
   output store_stat_type                  stat,
   output logic [VALUE_BITS-1:0]           found_value
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int IDX_W  = $clog2(NAME_MAX);
   localparam int LEN_W  = $clog2(NAME_MAX + 1);
   localparam int ADDR_W = $clog2(SLOTS * NAME_MAX);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_COPY,
      S_CMP
   } store_state_type;

   logic [CHAR_W-1:0]     key_mem  [NAME_MAX];
   logic [CHAR_W-1:0]     name_mem [SLOTS * NAME_MAX];
   logic [LEN_W-1:0]      len_mem  [SLOTS];
   logic [VALUE_BITS-1:0] val_mem  [SLOTS];

   store_state_type       state_ff, state_in;
   func_type              func_ff, func_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [ADDR_W-1:0]     base_ff, base_in;
   logic [LEN_W-1:0]      idx_ff, idx_in;
   logic                  pipe_v_ff, pipe_v_in;
   logic [IDX_W-1:0]      pipe_idx_ff, pipe_idx_in;
   logic                  diff_ff, diff_in;
   logic [SLOTS-1:0]      occ_ff, occ_in;
   logic                  done_ff, done_in;
   logic                  ok_ff, ok_in;
   logic [VALUE_BITS-1:0] found_ff, found_in;

   logic [CHAR_W-1:0]     key_rd_ff;
   logic [CHAR_W-1:0]     name_rd_ff;
   logic [LEN_W-1:0]      len_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;

   logic                  walking;
   logic                  issue;
   logic [IDX_W-1:0]      rd_idx;
   logic [ADDR_W-1:0]     name_rd_addr;
   logic [ADDR_W-1:0]     name_wr_addr;
   logic                  name_wr_en;
   logic                  meta_wr_en;
   logic                  byte_diff;
   logic                  walk_end;
   logic                  hit;

   assign walking      = (state_ff == S_COPY) || (state_ff == S_CMP);
   assign issue        = walking && (idx_ff < len_ff);
   assign rd_idx       = idx_ff[IDX_W-1:0];
   assign name_rd_addr = base_ff + ADDR_W'(rd_idx);
   assign name_wr_addr = base_ff + ADDR_W'(pipe_idx_ff);
   assign name_wr_en   = (state_ff == S_COPY) && pipe_v_ff;
   assign byte_diff    = pipe_v_ff && (key_rd_ff != name_rd_ff);
   // The final byte is in the read registers once no further read is issued.
   assign walk_end     = !issue && pipe_v_ff;
   assign hit          = !(diff_ff || byte_diff);

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      slot_in     = slot_ff;
      len_in      = len_ff;
      value_in    = value_ff;
      base_in     = base_ff;
      idx_in      = issue ? idx_ff + LEN_W'(1) : idx_ff;
      pipe_v_in   = issue;
      pipe_idx_in = rd_idx;
      diff_in     = diff_ff || byte_diff;
      occ_in      = occ_ff;
      done_in     = 1'b0;
      ok_in       = ok_ff;
      found_in    = found_ff;
      meta_wr_en  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               func_in  = cmd.func;
               slot_in  = cmd_slot;
               len_in   = cmd_len;
               value_in = cmd_value;
               base_in  = ADDR_W'(ADDR_W'(cmd_slot) * ADDR_W'(NAME_MAX));
               idx_in   = '0;
               diff_in  = 1'b0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (func_ff)
               FUNC_INSERT: begin
                  if (occ_ff[slot_ff]) begin
                     done_in  = 1'b1;
                     ok_in    = 1'b0;
                     found_in = '0;
                     state_in = S_IDLE;
                  end else begin
                     meta_wr_en      = 1'b1;
                     occ_in[slot_ff] = 1'b1;
                     if (len_ff == '0) begin
                        done_in  = 1'b1;
                        ok_in    = 1'b1;
                        found_in = '0;
                        state_in = S_IDLE;
                     end else begin
                        state_in = S_COPY;
                     end
                  end
               end
               FUNC_LOOKUP, FUNC_DELETE: begin
                  if (!occ_ff[slot_ff] || (len_rd_ff != len_ff)) begin
                     done_in  = 1'b1;
                     ok_in    = 1'b0;
                     found_in = '0;
                     state_in = S_IDLE;
                  end else if (len_ff == '0) begin
                     done_in  = 1'b1;
                     ok_in    = 1'b1;
                     found_in = val_rd_ff;
                     if (func_ff == FUNC_DELETE) begin
                        occ_in[slot_ff] = 1'b0;
                     end
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_CMP;
                  end
               end
               default: begin
                  done_in  = 1'b1;
                  ok_in    = 1'b0;
                  found_in = '0;
                  state_in = S_IDLE;
               end
            endcase
         end
         S_COPY: begin
            if (walk_end) begin
               done_in  = 1'b1;
               ok_in    = 1'b1;
               found_in = '0;
               state_in = S_IDLE;
            end
         end
         S_CMP: begin
            if (walk_end) begin
               done_in  = 1'b1;
               ok_in    = hit;
               found_in = hit ? val_rd_ff : '0;
               if (hit && (func_ff == FUNC_DELETE)) begin
                  occ_in[slot_ff] = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         occ_ff    <= '0;
         done_ff   <= 1'b0;
         pipe_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         done_ff   <= done_in;
         pipe_v_ff <= pipe_v_in;
      end
      func_ff     <= func_in;
      slot_ff     <= slot_in;
      len_ff      <= len_in;
      value_ff    <= value_in;
      base_ff     <= base_in;
      idx_ff      <= idx_in;
      pipe_idx_ff <= pipe_idx_in;
      diff_ff     <= diff_in;
      ok_ff       <= ok_in;
      found_ff    <= found_in;
   end

   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[key_wr_addr] <= key_wr_data;
      end
      key_rd_ff <= key_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (name_wr_en) begin
         name_mem[name_wr_addr] <= key_rd_ff;
      end
      name_rd_ff <= name_mem[name_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (meta_wr_en) begin
         len_mem[slot_ff] <= len_ff;
         val_mem[slot_ff] <= value_ff;
      end
      if ((state_ff == S_IDLE) && cmd.start) begin
         len_rd_ff <= len_mem[cmd_slot];
         val_rd_ff <= val_mem[cmd_slot];
      end
   end

   assign stat.done   = done_ff;
   assign stat.ok     = ok_ff;
   assign found_value = found_ff;

endmodule

`default_nettype wire

>>> hw/rtl/direct_mapped_name_table.sv
// Each name byte that is hashed holds off the next item until its hash is done;
// a zero byte or a byte past the name limit is taken without hashing. The hash
// shares one multiplier. The item marked last starts the table operation, in
// which the stored name is copied or compared one byte per cycle, or which the
// slot check alone settles. Reset is synchronous and empties the table at once,
// with no clearing pass.
// ---------------------------------------------------------------------------
// Direct-mapped name table
// Hashes a name arriving one byte per item into a slot and performs insert,
// lookup or delete on that slot, without collision handling; other codes fail.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module direct_mapped_name_table import dmnt_pkg::*; #(
   parameter int SLOTS      = SLOTS_DEF,
   parameter int NAME_MAX   = NAME_MAX_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   dmnt_req_if.sink    req_if,
   dmnt_rsp_if.source  rsp_if
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int IDX_W  = $clog2(NAME_MAX);
   localparam int LEN_W  = $clog2(NAME_MAX + 1);

   typedef enum logic [1:0] {
      T_IDLE,
      T_HASH,
      T_OP,
      T_RESP
   } top_state_type;

   top_state_type          state_ff, state_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [SLOT_W-1:0]      hash_ff, hash_in;
   logic                   ended_ff, ended_in;
   logic                   last_ff, last_in;
   func_type               func_ff, func_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic                   start_ff, start_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [VALUE_W-1:0]     rsp_value_ff, rsp_value_in;

   logic                   accept;
   logic                   take;
   logic                   rsp_free;
   logic                   hash_done;
   logic [SLOT_W-1:0]      hash_result;
   store_cmd_type          store_cmd;
   store_stat_type         store_stat;
   logic [VALUE_BITS-1:0]  store_found;

   assign req_if.ready = (state_ff == T_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   // A byte is kept only before the terminating zero and below the name limit.
   assign take         = accept && !ended_ff && (req_if.name_char != '0)
                         && (len_ff < LEN_W'(NAME_MAX));
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   assign store_cmd.start = start_ff;
   assign store_cmd.func  = func_ff;

   dmnt_hash #(
      .SLOTS   (SLOTS)
   ) u_hash (
      .clock   (clock),
      .reset   (reset),
      .start   (take),
      .acc_in  (hash_ff),
      .char_in (req_if.name_char),
      .done    (hash_done),
      .result  (hash_result)
   );

   dmnt_store #(
      .SLOTS       (SLOTS),
      .NAME_MAX    (NAME_MAX),
      .VALUE_BITS  (VALUE_BITS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .key_wr_en   (take),
      .key_wr_addr (len_ff[IDX_W-1:0]),
      .key_wr_data (req_if.name_char),
      .cmd         (store_cmd),
      .cmd_slot    (hash_ff),
      .cmd_len     (len_ff),
      .cmd_value   (value_ff),
      .stat        (store_stat),
      .found_value (store_found)
   );

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      hash_in      = hash_ff;
      ended_in     = ended_ff;
      last_in      = last_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_value_in = rsp_value_ff;
      case (state_ff)
         T_IDLE: begin
            if (accept) begin
               last_in  = req_if.last;
               func_in  = func_type'(req_if.func);
               value_in = VALUE_BITS'(req_if.value);
               if (!ended_ff && (req_if.name_char == '0)) begin
                  ended_in = 1'b1;
               end
               if (take) begin
                  len_in   = len_ff + LEN_W'(1);
                  state_in = T_HASH;
               end else if (req_if.last) begin
                  start_in = 1'b1;
                  state_in = T_OP;
               end
            end
         end
         T_HASH: begin
            if (hash_done) begin
               hash_in = hash_result;
               if (last_ff) begin
                  start_in = 1'b1;
                  state_in = T_OP;
               end else begin
                  state_in = T_IDLE;
               end
            end
         end
         T_OP: begin
            if (store_stat.done) begin
               state_in = T_RESP;
            end
         end
         T_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = store_stat.ok;
               rsp_slot_in  = SLOT_OUT_W'(hash_ff);
               rsp_value_in = VALUE_W'(store_found);
               len_in       = '0;
               hash_in      = '0;
               ended_in     = 1'b0;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         len_ff       <= '0;
         hash_ff      <= '0;
         ended_ff     <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         hash_ff      <= hash_in;
         ended_ff     <= ended_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff      <= last_in;
      func_ff      <= func_in;
      value_ff     <= value_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.ok          = rsp_ok_ff;
   assign rsp_if.slot        = rsp_slot_ff;
   assign rsp_if.found_value = rsp_value_ff;

   a_store_done_in_op: assert property (@(posedge clock) disable iff (reset)
      store_stat.done |-> (state_ff == T_OP))
      else $error("table store finished outside an operation");

   a_hash_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> (state_ff == T_HASH))
      else $error("hash unit finished while no byte was being hashed");

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(NAME_MAX))
      else $error("key length passed the name limit");

   a_key_cleared: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == T_RESP) && rsp_free) |=>
         ((len_ff == '0) && !ended_ff && rsp_valid_ff))
      else $error("key state not cleared when the result was issued");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// Name table regression
// Streams name bytes into the table with insert, lookup and delete requests,
// predicts every outcome from a behavioural copy of the slot store, and
// checks each response field by field under random gaps and back-pressure.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import dmnt_pkg::*;

   localparam int SLOT_COUNT   = SLOTS_DEF;
   localparam int NAME_LIMIT   = NAME_MAX_DEF;
   localparam int GAP_MAX      = 12;
   localparam int QUIET_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 480;
   localparam int POOL_SIZE    = 12;
   localparam int POOL_LEN_MAX = 8;
   localparam int PRINT_LIMIT  = 50;
   localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

   typedef logic [CHAR_W-1:0] name_q_type[$];

   typedef struct packed {
      logic                  ok;
      logic [SLOT_OUT_W-1:0] slot;
      logic [VALUE_W-1:0]    found_value;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;

   dmnt_req_if req ();
   dmnt_rsp_if rsp ();

   direct_mapped_name_table u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Behavioural copy of the key being received and of the slot store.
   logic [CHAR_W-1:0]  key_bytes [NAME_LIMIT];
   int                 key_len  = 0;
   int                 key_hash = 0;
   bit                 key_done = 1'b0;
   logic [CHAR_W-1:0]  slot_name_bytes [SLOT_COUNT][NAME_LIMIT];
   int                 slot_name_len [SLOT_COUNT];
   logic [VALUE_W-1:0] slot_value [SLOT_COUNT];
   bit                 slot_used [SLOT_COUNT];

   outcome_type expected_outcomes[$];
   int          error_count  = 0;
   int          items_sent   = 0;
   int          quiet_cycles = 0;
   bit          no_idle      = 1'b0;

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT) begin
         $display("%0t: mismatch: %s", $time, what);
      end
      error_count++;
   endtask

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   // Folds one accepted item into the key and, on the final item of an
   // operation, works out the outcome and updates the slot store.
   function automatic void predict_name_op(input logic [FUNC_W-1:0] f,
                                           input logic [CHAR_W-1:0] c,
                                           input logic last,
                                           input logic [VALUE_W-1:0] v);
      int          s;
      bit          hit;
      outcome_type res;
      if (!key_done) begin
         if (c == '0) begin
            key_done = 1'b1;
         end else if (key_len < NAME_LIMIT) begin
            key_bytes[key_len] = c;
            key_len++;
            key_hash = ((key_hash + int'(c)) * int'(c)) % SLOT_COUNT;
         end
      end
      if (!last) return;

      s   = key_hash;
      hit = slot_used[s] && (slot_name_len[s] == key_len);
      for (int i = 0; i < key_len; i++) begin
         if (slot_name_bytes[s][i] !== key_bytes[i]) hit = 1'b0;
      end

      res      = '0;
      res.slot = s[SLOT_OUT_W-1:0];
      case (f)
         FUNC_INSERT: begin
            if (!slot_used[s]) begin
               for (int i = 0; i < key_len; i++) slot_name_bytes[s][i] = key_bytes[i];
               slot_name_len[s] = key_len;
               slot_value[s]    = v;
               slot_used[s]     = 1'b1;
               res.ok           = 1'b1;
            end
         end
         FUNC_LOOKUP, FUNC_DELETE: begin
            if (hit) begin
               res.ok          = 1'b1;
               res.found_value = slot_value[s];
               if (f == FUNC_DELETE) slot_used[s] = 1'b0;
            end
         end
         default: begin
         end
      endcase
      expected_outcomes.push_back(res);

      key_len  = 0;
      key_hash = 0;
      key_done = 1'b0;
   endfunction

   function automatic int name_hash(input name_q_type nm);
      int h = 0;
      int n = 0;
      foreach (nm[i]) begin
         if (nm[i] == '0) break;
         if (n < NAME_LIMIT) begin
            h = ((h + int'(nm[i])) * int'(nm[i])) % SLOT_COUNT;
            n++;
         end
      end
      return h;
   endfunction

   function automatic name_q_type random_name(input int len);
      name_q_type nm;
      repeat (len) nm.push_back(CHAR_W'($urandom_range(1, 255)));
      return nm;
   endfunction

   // Sends one item; valid stays high afterwards unless the next item
   // starts with a gap.
   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                            input logic last, input logic [VALUE_W-1:0] v);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.func      <= f;
      req.name_char <= c;
      req.last      <= last;
      req.value     <= v;
      do @(posedge clock); while (!req.ready);
      predict_name_op(f, c, last, v);
      items_sent++;
   endtask

   // Only the final item's operation and value matter, so the earlier items
   // carry random ones.
   task automatic send_name(input logic [FUNC_W-1:0] f, input name_q_type nm,
                            input logic [VALUE_W-1:0] v);
      if (nm.size() == 0) begin
         send_item(f, '0, 1'b1, v);
      end else begin
         foreach (nm[i]) begin
            if (i == nm.size() - 1) begin
               send_item(f, nm[i], 1'b1, v);
            end else begin
               send_item(FUNC_W'($urandom), nm[i], 1'b0, VALUE_W'($urandom));
            end
         end
      end
   endtask

   task automatic clear_slots();
      name_q_type nm;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if (slot_used[s]) begin
            nm = {};
            for (int i = 0; i < slot_name_len[s]; i++) nm.push_back(slot_name_bytes[s][i]);
            send_name(FUNC_DELETE, nm, VALUE_W'($urandom));
         end
      end
   endtask

   // The empty name and the names 04 and 08 all hash to slot 0, which gives
   // collisions and length and content mismatches on a single slot.
   task automatic test_special_names();
      name_q_type empty_name;
      send_name(FUNC_INSERT, empty_name, 16'hffff);
      send_name(FUNC_LOOKUP, '{8'h04}, 16'h0000);
      send_name(FUNC_INSERT, '{8'h08}, 16'h1111);
      send_name(FUNC_LOOKUP, empty_name, 16'h0000);
      send_name(FUNC_UNKNOWN, '{8'hff, 8'h01}, 16'hffff);
      send_name(FUNC_DELETE, '{8'h04}, 16'h0000);
      send_name(FUNC_DELETE, empty_name, 16'h0000);
      send_name(FUNC_LOOKUP, empty_name, 16'h0000);
      send_name(FUNC_INSERT, '{8'h04}, 16'h0000);
      send_name(FUNC_LOOKUP, '{8'h08}, 16'hffff);
      send_name(FUNC_INSERT, '{8'h61, 8'h62, 8'h00, 8'h7a, 8'h7a}, 16'h1234);
      send_name(FUNC_LOOKUP, '{8'h61, 8'h62}, 16'h0000);
      send_name(FUNC_LOOKUP, '{8'h61, 8'h62, 8'h00}, 16'h0000);
      send_name(FUNC_DELETE, '{8'h61, 8'h62, 8'h00, 8'h00, 8'hff}, 16'h0000);
      send_name(FUNC_INSERT, '{8'hff, 8'hff, 8'hff, 8'hff}, 16'h8000);
      send_name(FUNC_LOOKUP, '{8'hff, 8'hff, 8'hff, 8'hff}, 16'h7fff);
      send_name(FUNC_UNKNOWN, '{8'hff, 8'hff, 8'hff, 8'hff}, 16'h0001);
      send_name(FUNC_LOOKUP, '{8'h04}, 16'h0000);
      clear_slots();
      // A leading zero byte leaves an empty name whatever follows.
      send_name(FUNC_INSERT, '{8'h00, 8'h55, 8'h66}, 16'habcd);
      send_name(FUNC_LOOKUP, empty_name, 16'h0000);
   endtask

   // Names beyond the length limit are truncated, and the compare must
   // cover every stored byte, not just the first few.
   task automatic test_long_names();
      name_q_type full_name, head, twin;
      int         target;
      int         alt;
      int         spots[1] = '{200};
      clear_slots();
      full_name = random_name(NAME_LIMIT + 4);
      send_name(FUNC_INSERT, full_name, VALUE_W'($urandom));
      head = full_name[0:NAME_LIMIT-1];
      target = name_hash(head);
      foreach (spots[k]) begin
         twin = head;
         for (alt = 1; alt < 256; alt++) begin
            twin[spots[k]] = CHAR_W'(alt);
            if (twin[spots[k]] != head[spots[k]] && name_hash(twin) == target) break;
         end
         send_name(FUNC_LOOKUP, twin, VALUE_W'($urandom));
      end
      send_name(FUNC_DELETE, full_name[0:NAME_LIMIT], VALUE_W'($urandom));
   endtask

   // Mostly well-formed operations on a small pool of names, so that
   // lookups and deletes often hit, with malformed and odd names mixed in.
   task automatic test_random_traffic();
      logic [CHAR_W-1:0] pool_bytes [POOL_SIZE][POOL_LEN_MAX];
      int                pool_len [POOL_SIZE];
      name_q_type        nm;
      int                pick;
      int                kind;
      int                first_item;
      logic [FUNC_W-1:0] f;
      for (int p = 0; p < POOL_SIZE; p++) begin
         pool_len[p] = $urandom_range(1, POOL_LEN_MAX);
         for (int i = 0; i < POOL_LEN_MAX; i++) pool_bytes[p][i] = CHAR_W'($urandom_range(1, 255));
      end
      clear_slots();
      first_item = items_sent;
      while (items_sent < first_item + RANDOM_ITEMS) begin
         if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
         if ($urandom_range(0, 59) == 0) clear_slots();
         pick = $urandom_range(0, POOL_SIZE - 1);
         if ($urandom_range(0, 19) == 0) begin
            pool_len[pick] = $urandom_range(1, POOL_LEN_MAX);
            for (int i = 0; i < POOL_LEN_MAX; i++) begin
               pool_bytes[pick][i] = CHAR_W'($urandom_range(1, 255));
            end
         end
         nm = {};
         for (int i = 0; i < pool_len[pick]; i++) nm.push_back(pool_bytes[pick][i]);

         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            f = FUNC_INSERT;
         end else if (kind < 60) begin
            f = FUNC_LOOKUP;
         end else if (kind < 80) begin
            f = FUNC_DELETE;
         end else begin
            f = FUNC_W'($urandom);
            case ($urandom_range(0, 4))
               0: f = FUNC_UNKNOWN;
               1: nm = {};
               2: begin
                  nm.push_back('0);
                  nm = {nm, random_name($urandom_range(0, 4))};
               end
               3: nm = random_name($urandom_range(9, 40));
               default: begin
                  if ($urandom_range(0, 7) == 0) begin
                     nm = random_name($urandom_range(NAME_LIMIT - 2, NAME_LIMIT + 6));
                  end else begin
                     nm[$urandom_range(0, nm.size() - 1)] = CHAR_W'($urandom_range(1, 255));
                  end
               end
            endcase
         end
         send_name(f, nm, VALUE_W'($urandom));
      end
      no_idle = 1'b0;
   endtask

   initial begin : result_checker
      outcome_type want;
      int          stall;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (reset || !rsp.valid);
         if (expected_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected result: ok %0b slot %0d value %h",
                                      rsp.ok, rsp.slot, rsp.found_value));
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp.ok !== want.ok) begin
               report_mismatch($sformatf("ok %0b, expected %0b (slot %0d)",
                                         rsp.ok, want.ok, want.slot));
            end
            if (rsp.slot !== want.slot) begin
               report_mismatch($sformatf("slot %0d, expected %0d", rsp.slot, want.slot));
            end
            if (rsp.found_value !== want.found_value) begin
               report_mismatch($sformatf("found_value %h, expected %h (slot %0d)",
                                         rsp.found_value, want.found_value, want.slot));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("direct_mapped_name_table regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.func      <= FUNC_INSERT;
      req.name_char <= '0;
      req.last      <= 1'b0;
      req.value     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_special_names();
      test_long_names();
      test_random_traffic();
      req.valid <= 1'b0;

      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("direct_mapped_name_table regression: pass");
      end else begin
         $display("direct_mapped_name_table regression: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/dmnt_pkg.sv
hw/rtl/dmnt_req_if.sv
hw/rtl/dmnt_rsp_if.sv
hw/rtl/dmnt_hash.sv
hw/rtl/dmnt_store.sv
hw/rtl/direct_mapped_name_table.sv
bench/testbench.sv
